// ===== rtl/fsmvp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsmvp_pkg
// Shared types and constants of the fair-share minimum-vruntime picker.
// ----------------------------------------------------------------------------
package fsmvp_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SLOT_W     = 6;
	localparam int TIME_W     = 32;
	localparam int MASK_W     = 64;
	localparam int RT_W       = 32;

	localparam logic [RT_W-1:0] RUNTIME_MAX = '1;

	// action codes on the input port
	localparam logic [1:0] ACT_CREATE = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_EXIT   = 2'd2;
	localparam logic [1:0] ACT_PICK   = 2'd3;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_CREATE,
		OP_TICK,
		OP_EXIT,
		OP_PICK,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        slot;
		logic [TIME_W-1:0]       ctime;
		logic [SLOT_COUNT-1:0]   mask;
	} cmd_t;

	typedef struct packed {
		logic                    picked_valid;
		logic [SLOT_W-1:0]       picked_slot;
		logic [RT_W-1:0]         floor_runtime;
	} res_t;

endpackage

// ===== rtl/fsmvp_front.sv =====
// ----------------------------------------------------------------------------
// fsmvp_front
// Accepts events, classifies them and queues them for the back end. The
// scan mask is prepared here: runnable slots for a pick, live slots other
// than the named one for create and exit.
// ----------------------------------------------------------------------------
module fsmvp_front
	import fsmvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        action,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] create_time,
	input  logic [MASK_W-1:0] live_mask,
	input  logic [MASK_W-1:0] runnable_mask,
	output logic              cmd_avail,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(SLOT_COUNT);
	localparam logic [1:0]      CQ_DEPTH   = 2'd2;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       in_range;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		in_range  = ({1'b0, slot} < SLOT_LIMIT);
		cls.slot  = slot[IDX_W-1:0];
		cls.ctime = create_time;
		cls.mask  = live_mask[SLOT_COUNT-1:0];
		case (action)
			ACT_CREATE: cls.op = in_range ? OP_CREATE : OP_NOP;
			ACT_TICK:   cls.op = in_range ? OP_TICK : OP_NOP;
			ACT_EXIT:   cls.op = in_range ? OP_EXIT : OP_NOP;
			default:    cls.op = OP_PICK;
		endcase
		if (cls.op == OP_PICK) begin
			cls.mask = runnable_mask[SLOT_COUNT-1:0];
		end
		// drop the named slot from the minimum search
		if (cls.op == OP_CREATE || cls.op == OP_EXIT) begin
			cls.mask[cls.slot] = 1'b0;
		end
	end

	assign full      = (cnt_q == CQ_DEPTH);
	assign cmd_avail = (cnt_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/fsmvp_back.sv =====
// ----------------------------------------------------------------------------
// fsmvp_back
// Carries out one event at a time against the runtime and creation-time
// memories. Create, exit and pick sweep all slots through one comparator,
// one memory read per cycle; tick is a read followed by a write.
// ----------------------------------------------------------------------------
module fsmvp_back
	import fsmvp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_avail,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_WR,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_RESULT
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [IDX_W-1:0]      slot_q;
	logic [SLOT_COUNT-1:0] mask_q;
	logic [RT_W-1:0]       min_q;
	logic [IDX_W-1:0]      idx_q;
	res_t                  res_q;

	logic                  best_any_q;
	logic [RT_W-1:0]       best_v_q;
	logic [TIME_W-1:0]     best_c_q;
	logic [IDX_W-1:0]      best_i_q;

	logic [RT_W-1:0]       vr_mem [SLOT_COUNT];
	logic [TIME_W-1:0]     ct_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] vr_vld_q;
	logic [SLOT_COUNT-1:0] ct_vld_q;

	logic [RT_W-1:0]       vr_rd_s1;
	logic [TIME_W-1:0]     ct_rd_s1;
	logic                  vr_ok_s1;
	logic                  ct_ok_s1;
	logic                  inc_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic [IDX_W-1:0]      rd_addr;
	logic                  vr_we;
	logic [IDX_W-1:0]      vr_wa;
	logic [RT_W-1:0]       vr_wd;
	logic                  ct_we;
	logic [RT_W-1:0]       cur_vr;
	logic [TIME_W-1:0]     cur_ct;
	logic                  better;
	logic [RT_W-1:0]       create_min;
	logic [RT_W-1:0]       exit_min;
	logic [RT_W-1:0]       tick_vr;
	res_t                  commit_res;

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_avail;
	assign res_push = (state_q == ST_RESULT) && !res_full;
	assign res      = res_q;

	// never-written entries read as zero
	assign cur_vr     = vr_ok_s1 ? vr_rd_s1 : '0;
	assign cur_ct     = ct_ok_s1 ? ct_rd_s1 : '0;
	assign create_min = best_any_q ? best_v_q : min_q;
	assign exit_min   = best_any_q ? best_v_q : '0;
	assign tick_vr    = (cur_vr == RUNTIME_MAX) ? cur_vr : cur_vr + 1'b1;
	assign better     = inc_s1 && (!best_any_q || cur_vr < best_v_q ||
		(op_q == OP_PICK && cur_vr == best_v_q && cur_ct < best_c_q));

	always_comb begin
		rd_addr = (state_q == ST_IDLE) ? cmd.slot : idx_q;
		vr_we   = 1'b0;
		vr_wa   = slot_q;
		vr_wd   = tick_vr;
		ct_we   = cmd_pop && (cmd.op == OP_CREATE);
		case (state_q)
			ST_IDLE: begin
				vr_we = cmd_pop && (cmd.op == OP_EXIT);
				vr_wa = cmd.slot;
				vr_wd = min_q;
			end
			ST_TICK_WR: begin
				vr_we = 1'b1;
			end
			ST_COMMIT: begin
				vr_we = (op_q == OP_CREATE);
				vr_wd = create_min;
			end
			default: begin
				vr_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		commit_res = '{picked_valid: 1'b0, picked_slot: '0, floor_runtime: min_q};
		case (op_q)
			OP_PICK: begin
				if (best_any_q) begin
					commit_res = '{picked_valid: 1'b1,
						picked_slot: SLOT_W'(best_i_q),
						floor_runtime: best_v_q};
				end
			end
			OP_CREATE: begin
				commit_res.floor_runtime = create_min;
			end
			OP_EXIT: begin
				commit_res.floor_runtime = exit_min;
			end
			default: begin
				commit_res.floor_runtime = min_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vr_we) begin
			vr_mem[vr_wa] <= vr_wd;
		end
		if (ct_we) begin
			ct_mem[cmd.slot] <= cmd.ctime;
		end
		vr_rd_s1 <= vr_mem[rd_addr];
		ct_rd_s1 <= ct_mem[rd_addr];
		idx_s1   <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_NOP;
			slot_q     <= '0;
			mask_q     <= '0;
			min_q      <= '0;
			idx_q      <= '0;
			res_q      <= '0;
			best_any_q <= 1'b0;
			best_v_q   <= '0;
			best_c_q   <= '0;
			best_i_q   <= '0;
			vr_vld_q   <= '0;
			ct_vld_q   <= '0;
			vr_ok_s1   <= 1'b0;
			ct_ok_s1   <= 1'b0;
			inc_s1     <= 1'b0;
		end else begin
			vr_ok_s1 <= vr_vld_q[rd_addr];
			ct_ok_s1 <= ct_vld_q[rd_addr];
			inc_s1   <= (state_q == ST_SCAN) && mask_q[idx_q];
			if (vr_we) begin
				vr_vld_q[vr_wa] <= 1'b1;
			end
			if (ct_we) begin
				ct_vld_q[cmd.slot] <= 1'b1;
			end
			if (better) begin
				best_any_q <= 1'b1;
				best_v_q   <= cur_vr;
				best_c_q   <= cur_ct;
				best_i_q   <= idx_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						op_q       <= cmd.op;
						slot_q     <= cmd.slot;
						mask_q     <= cmd.mask;
						idx_q      <= '0;
						best_any_q <= 1'b0;
						case (cmd.op)
							OP_TICK:   state_q <= ST_TICK_WR;
							OP_CREATE: state_q <= ST_SCAN;
							OP_EXIT:   state_q <= ST_SCAN;
							OP_PICK:   state_q <= ST_SCAN;
							default:   state_q <= ST_COMMIT;
						endcase
					end
				end
				ST_TICK_WR: begin
					res_q   <= '{picked_valid: 1'b0, picked_slot: '0, floor_runtime: min_q};
					state_q <= ST_RESULT;
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					case (op_q)
						OP_PICK: begin
							if (best_any_q) begin
								min_q <= best_v_q;
							end
						end
						OP_CREATE: begin
							min_q <= create_min;
						end
						OP_EXIT: begin
							min_q <= exit_min;
						end
						default: begin
							min_q <= min_q;
						end
					endcase
					res_q   <= commit_res;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && res_q.picked_valid) |-> (op_q == OP_PICK))
		else $error("picked_valid set on a non-pick event");

	a_pick_runnable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && op_q == OP_PICK && best_any_q) |-> mask_q[best_i_q])
		else $error("chosen slot is not runnable");

	a_pick_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && op_q == OP_PICK && best_any_q) |=>
		(min_q == $past(best_v_q)))
		else $error("kept minimum not taken from the chosen slot");

endmodule

// ===== rtl/fsmvp_outq.sv =====
// ----------------------------------------------------------------------------
// fsmvp_outq
// Two-entry result queue; the oldest result sits on the output ports.
// ----------------------------------------------------------------------------
module fsmvp_outq
	import fsmvp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_in,
	output logic res_full,
	output logic empty,
	input  logic pop,
	output res_t res_out
);

	localparam logic [1:0] RQ_DEPTH = 2'd2;

	res_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (cnt_q == RQ_DEPTH);
	assign empty    = (cnt_q == 2'd0);
	assign res_out  = entry_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("pushed result lost from the queue");

endmodule

// ===== rtl/fair_share_min_vruntime_picker.sv =====
// ----------------------------------------------------------------------------
// fair_share_min_vruntime_picker
// Flow: create, exit and pick sweep every slot in the back end (one slot
//   read per cycle); tick and an out-of-range create, tick or exit skip the
//   sweep. The back end finishes one event before it takes the next; the
//   input queue holds up to two waiting events.
// Reset: arst_n clears queues, control and the kept minimum at once; the
//   per-slot valid bits make every runtime and creation time read as zero.
// ----------------------------------------------------------------------------
module fair_share_min_vruntime_picker
	import fsmvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        action,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] create_time,
	input  logic [MASK_W-1:0] live_mask,
	input  logic [MASK_W-1:0] runnable_mask,
	output logic              empty,
	input  logic              pop,
	output logic              picked_valid,
	output logic [SLOT_W-1:0] picked_slot,
	output logic [RT_W-1:0]   floor_runtime
);

	logic cmd_avail;
	cmd_t cmd;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res;
	res_t res_out;

	fsmvp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.slot          (slot),
		.create_time   (create_time),
		.live_mask     (live_mask),
		.runnable_mask (runnable_mask),
		.cmd_avail     (cmd_avail),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	fsmvp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (cmd_avail),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	fsmvp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign picked_valid  = res_out.picked_valid;
	assign picked_slot   = res_out.picked_slot;
	assign floor_runtime = res_out.floor_runtime;

endmodule

// ===== sim/picker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// picker_checker
// Watches both queue ports of the vruntime picker, keeps its own copy of the
// per-slot runtimes, creation times and kept minimum, predicts the result of
// every accepted event and compares each popped result field by field.
// ----------------------------------------------------------------------------
module picker_checker
	import fsmvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [1:0]        action,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] create_time,
	input  logic [MASK_W-1:0] live_mask,
	input  logic [MASK_W-1:0] runnable_mask,
	input  logic              empty,
	input  logic              pop,
	input  logic              picked_valid,
	input  logic [SLOT_W-1:0] picked_slot,
	input  logic [RT_W-1:0]   floor_runtime,
	output int                errors,
	output int                pending,
	output int                checked
);

	logic [RT_W-1:0]   vruntime [SLOT_COUNT];
	logic [TIME_W-1:0] born_at  [SLOT_COUNT];
	logic [RT_W-1:0]   kept_floor;
	res_t              due_results [$];
	int                err_count;
	int                n_checked;

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t ns: result %0d: %s expected 0x%0h got 0x%0h",
			$time, n_checked, what, want, got);
		err_count++;
	endtask

	// least runtime over the live slots other than skip
	function automatic logic [RT_W-1:0] min_live_runtime(input logic [MASK_W-1:0] live,
			input int skip, output logic found);
		logic [RT_W-1:0] low;
		low = '0;
		found = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (i != skip && live[i] && (!found || vruntime[i] < low)) begin
				low = vruntime[i];
				found = 1'b1;
			end
		end
		return low;
	endfunction

	function automatic res_t advance_scheduler(input logic [1:0] act,
			input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] ct,
			input logic [MASK_W-1:0] live, input logic [MASK_W-1:0] run);
		res_t              r;
		logic              found;
		logic [RT_W-1:0]   low;
		logic [RT_W-1:0]   best_vr;
		logic [TIME_W-1:0] best_ct;
		r = '0;
		best_vr = '0;
		best_ct = '0;
		if (act == ACT_PICK) begin
			// least runtime, then earlier creation, then lowest index
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (run[i] && (!r.picked_valid || vruntime[i] < best_vr ||
						(vruntime[i] == best_vr && born_at[i] < best_ct))) begin
					r.picked_valid = 1'b1;
					r.picked_slot = SLOT_W'(i);
					best_vr = vruntime[i];
					best_ct = born_at[i];
				end
			end
			if (r.picked_valid)
				kept_floor = best_vr;
		end else if (int'(s) < SLOT_COUNT) begin
			case (act)
				ACT_CREATE: begin
					born_at[s] = ct;
					low = min_live_runtime(live, int'(s), found);
					if (found)
						kept_floor = low;
					vruntime[s] = kept_floor;
				end
				ACT_TICK: begin
					if (vruntime[s] != RUNTIME_MAX)
						vruntime[s] = vruntime[s] + 1'b1;
				end
				default: begin
					vruntime[s] = kept_floor;
					low = min_live_runtime(live, int'(s), found);
					kept_floor = found ? low : '0;
				end
			endcase
		end
		r.floor_runtime = kept_floor;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				vruntime[i] = '0;
				born_at[i] = '0;
			end
			kept_floor = '0;
			due_results.delete();
			err_count = 0;
			n_checked = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// check before predicting so a stray result is never masked
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result, floor_runtime", 64'd0,
						64'(floor_runtime));
				end else begin
					want = due_results.pop_front();
					if (picked_valid !== want.picked_valid)
						report_mismatch("picked_valid", 64'(want.picked_valid),
							64'(picked_valid));
					if (picked_slot !== want.picked_slot)
						report_mismatch("picked_slot", 64'(want.picked_slot),
							64'(picked_slot));
					if (floor_runtime !== want.floor_runtime)
						report_mismatch("floor_runtime", 64'(want.floor_runtime),
							64'(floor_runtime));
				end
				n_checked++;
			end
			if (push && !full)
				due_results.push_back(advance_scheduler(action, slot, create_time,
					live_mask, runnable_mask));
			errors <= err_count;
			pending <= due_results.size();
			checked <= n_checked;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives scheduling events into the vruntime picker: a directed opening on
// ties, empty picks and lone-slot create/exit, then random traffic that
// follows a set of live slots, with random stalls on both queue ports.
// ----------------------------------------------------------------------------
module tb;
	import fsmvp_pkg::*;

	localparam int RANDOM_EVENTS = 800;
	localparam int CALM_TAIL     = 120;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 100;
	localparam int LIVE_CAP      = 12;
	localparam logic [MASK_W-1:0] ALL_SLOTS = '1;
	localparam logic [MASK_W-1:0] NO_SLOTS  = '0;
	localparam logic [MASK_W-1:0] ONE       = 64'd1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              pop = 1'b0;
	logic [1:0]        action = ACT_PICK;
	logic [SLOT_W-1:0] slot = '0;
	logic [TIME_W-1:0] create_time = '0;
	logic [MASK_W-1:0] live_mask = '0;
	logic [MASK_W-1:0] runnable_mask = '0;
	logic              full;
	logic              empty;
	logic              picked_valid;
	logic [SLOT_W-1:0] picked_slot;
	logic [RT_W-1:0]   floor_runtime;

	int                errors;
	int                pending;
	int                checked;
	logic              calm = 1'b0;
	int                pop_stall = 0;
	int                idle_cycles = 0;
	int                n_create = 0;
	int                n_tick = 0;
	int                n_exit = 0;
	int                n_pick = 0;
	logic [MASK_W-1:0] alive = '0;
	logic [TIME_W-1:0] now_time = '0;

	always #2 clk = ~clk;

	fair_share_min_vruntime_picker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.slot          (slot),
		.create_time   (create_time),
		.live_mask     (live_mask),
		.runnable_mask (runnable_mask),
		.empty         (empty),
		.pop           (pop),
		.picked_valid  (picked_valid),
		.picked_slot   (picked_slot),
		.floor_runtime (floor_runtime)
	);

	picker_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.slot          (slot),
		.create_time   (create_time),
		.live_mask     (live_mask),
		.runnable_mask (runnable_mask),
		.empty         (empty),
		.pop           (pop),
		.picked_valid  (picked_valid),
		.picked_slot   (picked_slot),
		.floor_runtime (floor_runtime),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	// result side: start random stalls on pops, but none in the calm tail
	always @(negedge clk) begin
		if (pop_stall > 0) begin
			pop_stall <= pop_stall - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			pop_stall <= $urandom_range(0, 10);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// abort when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_event(input logic [1:0] act, input logic [SLOT_W-1:0] s,
			input logic [TIME_W-1:0] ct, input logic [MASK_W-1:0] live,
			input logic [MASK_W-1:0] run);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		action <= act;
		slot <= s;
		create_time <= ct;
		live_mask <= live;
		runnable_mask <= run;
		do @(posedge clk); while (full);
		case (act)
			ACT_CREATE: n_create++;
			ACT_TICK:   n_tick++;
			ACT_EXIT:   n_exit++;
			default:    n_pick++;
		endcase
	endtask

	// hold the sender until every outstanding result has been popped
	task automatic drain_results;
		@(negedge clk);
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic random_event;
		logic [1:0]        act;
		logic [SLOT_W-1:0] s;
		logic [TIME_W-1:0] ct;
		logic [MASK_W-1:0] live;
		logic [MASK_W-1:0] run;
		int                roll;
		int                nlive;
		int                flip;
		roll = $urandom_range(0, 99);
		nlive = $countones(alive);
		// creation times crawl forward and often repeat to force ties
		now_time = now_time + TIME_W'($urandom_range(0, 2));
		ct = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom()) : now_time;
		if (roll < 8) begin
			act = 2'($urandom_range(0, 3));
			s = SLOT_W'($urandom_range(0, 63));
			live = {$urandom(), $urandom()};
			run = {$urandom(), $urandom()};
		end else begin
			if (nlive == 0 || (roll < 30 && nlive < LIVE_CAP))
				act = ACT_CREATE;
			else if (roll < 60)
				act = ACT_TICK;
			else if (roll < 74)
				act = ACT_EXIT;
			else
				act = ACT_PICK;
			if (act == ACT_CREATE) begin
				do s = SLOT_W'($urandom_range(0, 63)); while (alive[s]);
			end else begin
				do s = SLOT_W'($urandom_range(0, 63)); while (!alive[s]);
			end
			live = alive;
			case ($urandom_range(0, 3))
				0:       run = alive;
				1:       run = ONE << s;
				default: run = alive & {$urandom(), $urandom()};
			endcase
			// occasionally disagree with the tracked live set
			if ($urandom_range(0, 9) == 0) begin
				flip = $urandom_range(0, 63);
				live[flip] = ~live[flip];
			end
			if (act == ACT_CREATE)
				alive[s] = 1'b1;
			else if (act == ACT_EXIT)
				alive[s] = 1'b0;
		end
		send_event(act, s, ct, live, run);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pick, then a create with nobody else live and a create beside slot 0
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, NO_SLOTS);
		send_event(ACT_CREATE, 6'd0,  32'd0,        NO_SLOTS,  NO_SLOTS);
		send_event(ACT_CREATE, 6'd63, 32'hFFFFFFFF, ONE,       NO_SLOTS);
		send_event(ACT_TICK,   6'd0,  32'd0,        ONE,       ONE);
		send_event(ACT_TICK,   6'd0,  32'd0,        ONE,       ONE);
		send_event(ACT_TICK,   6'd0,  32'd0,        ONE,       ONE);
		send_event(ACT_CREATE, 6'd5,  32'd7,        ONE | (ONE << 63), NO_SLOTS);
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, ALL_SLOTS);
		// equal runtime: earlier creation wins, then the lower index
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, (ONE << 5) | (ONE << 63));
		send_event(ACT_CREATE, 6'd9,  32'd7,        ONE | (ONE << 5) | (ONE << 63), NO_SLOTS);
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, (ONE << 9) | (ONE << 5));
		send_event(ACT_TICK,   6'd63, 32'd0,        ALL_SLOTS, ALL_SLOTS);
		send_event(ACT_TICK,   6'd5,  32'd0,        ALL_SLOTS, ALL_SLOTS);
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, ONE | (ONE << 63) | (ONE << 5));
		send_event(ACT_EXIT,   6'd63, 32'd0,        ONE | (ONE << 5) | (ONE << 9) | (ONE << 63),
			ALL_SLOTS);
		// exit of the only live slot drops the floor to zero
		send_event(ACT_EXIT,   6'd0,  32'd0,        ONE,       ONE);
		send_event(ACT_TICK,   6'd9,  32'd0,        ALL_SLOTS, ALL_SLOTS);
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, ONE << 9);
		send_event(ACT_CREATE, 6'd0,  32'h80000000, NO_SLOTS,  ALL_SLOTS);
		send_event(ACT_CREATE, 6'd40, 32'h55555555, ALL_SLOTS, NO_SLOTS);
		send_event(ACT_PICK,   6'd0,  32'd0,        ALL_SLOTS, ALL_SLOTS);
		send_event(ACT_EXIT,   6'd40, 32'd0,        ALL_SLOTS, NO_SLOTS);
		drain_results();

		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n == RANDOM_EVENTS / 2)
				drain_results();
			if (n == RANDOM_EVENTS - CALM_TAIL)
				calm = 1'b1;
			random_event();
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d events (%0d create, %0d tick, %0d exit, %0d pick),",
			n_create + n_tick + n_exit + n_pick, n_create, n_tick, n_exit, n_pick);
		$display("%0d results checked; up to %0d live slots, stalls on both ports, calm tail",
			checked, LIVE_CAP);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fsmvp_pkg.sv
rtl/fsmvp_front.sv
rtl/fsmvp_back.sv
rtl/fsmvp_outq.sv
rtl/fair_share_min_vruntime_picker.sv
sim/picker_checker.sv
sim/tb.sv
